// ----- hdl/gcol_pkg.sv -----
// ----------------------------------------------------------------------------
// gcol_pkg
// Shared types and constants of the first-fit greedy graph coloring block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcol_pkg;

   localparam int ColorW    = 5;
   localparam int MaskW     = 16;
   localparam int ScanW     = 5;
   localparam int BlockW    = 32;
   localparam int CapW      = 7;
   localparam int ReqDataW  = 16;
   localparam int RspDataW  = 16;

   localparam logic [ColorW-1:0] LimitReset = 5'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/gcol_ram.sv -----
// ----------------------------------------------------------------------------
// gcol_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gcol_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/greedy_graph_coloring.sv -----
// ----------------------------------------------------------------------------
// greedy_graph_coloring
// First-fit greedy vertex coloring over a color RAM indexed by vertex.
// ----------------------------------------------------------------------------
// flow: after a request is accepted, the scan does one color RAM read per earlier
//    vertex, then the pick state registers the result; a set mask bit of vertex idx - 1
//    holds the scan while its read is pending, and a held result stalls the pick state
// requests: the next request is taken in idle only, also while the last result waits
// reset: synchronous, clears control, vertex counter, max color and limit (back to 10);
//    the color RAM is not cleared, only entries written in the running graph are read
`default_nettype none

module greedy_graph_coloring
   import gcol_pkg::*;
#(
   parameter int NUM_VERTICES = 16,
   parameter int MAX_COLORS   = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [ColorW-1:0]   csr_wdata,  // color_limit
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,  // neighbor_mask[15:0]
   input  wire logic                req_tlast,  // last_vertex
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [RspDataW-1:0] rsp_tdata,  // vertex_index[3:0], vertex_color[8:4],
                                                // no_color_flag[9], colors_used[14:10], 0
   output logic                     rsp_tlast   // last
);

   localparam int IdxW = $clog2(NUM_VERTICES);
   localparam int ExtW = ((IdxW > ScanW) ? IdxW : ScanW) + 1;

   state_type             state_ff, state_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic [ColorW-1:0]     max_ff, max_in;
   logic [MaskW-1:0]      mask_ff, mask_in;
   logic                  last_ff, last_in;
   logic [ScanW-1:0]      scan_ff, scan_in;
   logic [ScanW-1:0]      scan_end_ff, scan_end_in;
   logic                  pend_ff, pend_in;
   logic [BlockW-1:0]     blocked_ff, blocked_in;
   logic [ColorW-1:0]     limit_ff, limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]   rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [ColorW-1:0]     limit_eff;
   logic [ColorW-1:0]     pick_color;
   logic [ColorW-1:0]     used_color;
   logic [ColorW-1:0]     rd_color;
   logic [ExtW-1:0]       idx_ext;
   logic                  req_fire;
   logic                  pick_fire;
   logic                  issue;

   gcol_ram #(
      .WIDTH (ColorW),
      .DEPTH (NUM_VERTICES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (pick_fire),
      .wr_addr (idx_ff),
      .wr_data (pick_color),
      .rd_en   (issue),
      .rd_addr (IdxW'(scan_ff)),
      .rd_data (rd_color)
   );

   assign idx_ext   = ExtW'(idx_ff);
   assign req_fire  = req_tvalid && req_tready;
   assign pick_fire = (state_ff == ST_PICK) && (!rsp_valid_ff || rsp_tready);
   assign issue     = (state_ff == ST_SCAN) && (scan_ff < scan_end_ff);

   assign limit_eff = (CapW'(limit_ff) > CapW'(MAX_COLORS)) ? ColorW'(MAX_COLORS) : limit_ff;

   // first free color from 1 up to the limit (capped at MAX_COLORS), 0 when none is free
   always_comb begin
      pick_color = '0;
      for (int c = BlockW - 1; c >= 1; c--) begin
         if ((ColorW'(c) <= limit_eff) && !blocked_ff[c]) begin
            pick_color = ColorW'(c);
         end
      end
   end

   assign used_color = (pick_color > max_ff) ? pick_color : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         max_ff       <= '0;
         scan_ff      <= '0;
         scan_end_ff  <= '0;
         pend_ff      <= 1'b0;
         limit_ff     <= LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         max_ff       <= max_in;
         scan_ff      <= scan_in;
         scan_end_ff  <= scan_end_in;
         pend_ff      <= pend_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      last_ff     <= last_in;
      blocked_ff  <= blocked_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      max_in       = max_ff;
      mask_in      = mask_ff;
      last_in      = last_ff;
      scan_in      = scan_ff;
      scan_end_in  = scan_end_ff;
      pend_in      = 1'b0;
      blocked_in   = blocked_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mask_in     = req_tdata[MaskW-1:0];
               last_in     = req_tlast;
               scan_in     = '0;
               blocked_in  = '0;
               scan_end_in = (idx_ext >= ExtW'(MaskW)) ? ScanW'(MaskW) : ScanW'(idx_ext);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff && (rd_color != '0)) begin
               blocked_in[rd_color] = 1'b1;
            end
            if (issue) begin
               pend_in = mask_ff[scan_ff[ScanW-2:0]];
               scan_in = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (pick_fire) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               rsp_data_in  = {1'b0, used_color, (pick_color == '0), pick_color,
                               4'(idx_ff)};
               if (last_ff || ((idx_ext + 1'b1) >= ExtW'(NUM_VERTICES))) begin
                  idx_in = '0;
                  max_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  max_in = used_color;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= scan_end_ff))
      else $error("scan counter ran past its end");

   a_pick_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> (pick_color <= limit_eff))
      else $error("picked color above the limit");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (pick_fire && last_ff) |=> ((idx_ff == '0) && (max_ff == '0)))
      else $error("graph state not cleared after last vertex");

   a_used_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[14:10] >= rsp_data_ff[8:4]))
      else $error("colors used below the vertex color");

endmodule

`default_nettype wire
